### hw/rtl/hlf_pkg.sv
`timescale 1ns / 1ps

package hlf_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT / 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int USED_W      = ADDR_W + 1;

    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_ROW = 2'd1;
    localparam logic [1:0] STATUS_BAD_COL = 2'd2;
    localparam logic [1:0] STATUS_REVERSE = 2'd3;

    localparam logic REG_ROW_BYTES    = 1'b0;
    localparam logic REG_SCREEN_BYTES = 1'b1;

    localparam logic [4:0]  ROW_BYTES_RESET    = 5'd16;
    localparam logic [10:0] SCREEN_BYTES_RESET = 11'd1024;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_CHECK,
        ST_RD_WAIT,
        ST_HEAD,
        ST_FILL,
        ST_TAIL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [4:0]        row_bytes;
        logic [USED_W-1:0] used_bytes;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
    } res_t;

endpackage

### hw/rtl/hlf_ram.sv
`timescale 1ns / 1ps

module hlf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/hlf_ctrl.sv
`timescale 1ns / 1ps

module hlf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  hlf_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [6:0]        x_start,
    input  logic [6:0]        x_end,
    input  logic [9:0]        row,
    input  logic [9:0]        byte_addr,
    input  logic [7:0]        write_data,
    output logic              res_valid,
    input  logic              res_ready,
    output hlf_pkg::res_t     res,
    output hlf_pkg::mem_req_t mem_req,
    input  logic [7:0]        mem_rdata
);

    hlf_pkg::state_t state_reg, state_next;
    logic [hlf_pkg::ADDR_W-1:0] clr_reg, clr_next;

    logic [1:0]                 cmd_reg, cmd_next;
    logic [6:0]                 xs_reg, xs_next;
    logic [6:0]                 xe_reg, xe_next;
    logic [9:0]                 row_reg, row_next;
    logic [9:0]                 addr_reg, addr_next;
    logic [7:0]                 wdata_reg, wdata_next;
    logic [15:0]                prod_reg, prod_next;
    logic [14:0]                base_reg, base_next;
    logic [hlf_pkg::ADDR_W-1:0] cur_reg, cur_next;
    logic [hlf_pkg::ADDR_W-1:0] last_reg, last_next;
    logic [7:0]                 head_reg, head_next;
    logic [7:0]                 tail_reg, tail_next;
    logic                       single_reg, single_next;
    logic [1:0]                 status_reg, status_next;
    logic [7:0]                 rd_reg, rd_next;

    logic [hlf_pkg::ADDR_W-1:0] first_addr;
    logic [hlf_pkg::ADDR_W-1:0] last_addr;

    assign first_addr = hlf_pkg::ADDR_W'(base_reg) + hlf_pkg::ADDR_W'(xs_reg[6:3]);
    assign last_addr  = hlf_pkg::ADDR_W'(base_reg) + hlf_pkg::ADDR_W'(xe_reg[6:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hlf_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        xs_reg     <= xs_next;
        xe_reg     <= xe_next;
        row_reg    <= row_next;
        addr_reg   <= addr_next;
        wdata_reg  <= wdata_next;
        prod_reg   <= prod_next;
        base_reg   <= base_next;
        cur_reg    <= cur_next;
        last_reg   <= last_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        single_reg <= single_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        xs_next     = xs_reg;
        xe_next     = xe_reg;
        row_next    = row_reg;
        addr_next   = addr_reg;
        wdata_next  = wdata_reg;
        prod_next   = prod_reg;
        base_next   = base_reg;
        cur_next    = cur_reg;
        last_next   = last_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        single_next = single_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_req     = '0;

        unique case (state_reg)
            hlf_pkg::ST_CLEAR:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_reg;
                mem_req.wdata = 8'h00;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == hlf_pkg::ADDR_W'(hlf_pkg::STORE_DEPTH - 1))
                begin
                    state_next = hlf_pkg::ST_IDLE;
                end
            end
            hlf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = command;
                    xs_next    = x_start;
                    xe_next    = x_end;
                    row_next   = row;
                    addr_next  = byte_addr;
                    wdata_next = write_data;
                    state_next = hlf_pkg::ST_CALC;
                end
            end
            hlf_pkg::ST_CALC:
            begin
                prod_next  = 16'({1'b0, row_reg} + 11'd1) * 16'(cfg.row_bytes);
                base_next  = 15'(row_reg) * 15'(cfg.row_bytes);
                state_next = hlf_pkg::ST_CHECK;
            end
            hlf_pkg::ST_CHECK:
            begin
                status_next = hlf_pkg::STATUS_OK;
                rd_next     = 8'h00;
                state_next  = hlf_pkg::ST_DONE;
                case (cmd_reg)
                    hlf_pkg::CMD_DRAW:
                    begin
                        if (cfg.row_bytes == 5'd0
                            || prod_reg > 16'(cfg.used_bytes))
                        begin
                            status_next = hlf_pkg::STATUS_BAD_ROW;
                        end
                        else if ({1'b0, xs_reg[6:3]} >= cfg.row_bytes
                                 || {1'b0, xe_reg[6:3]} >= cfg.row_bytes)
                        begin
                            status_next = hlf_pkg::STATUS_BAD_COL;
                        end
                        else if (xe_reg < xs_reg)
                        begin
                            status_next = hlf_pkg::STATUS_REVERSE;
                        end
                        else
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = first_addr;
                            cur_next     = first_addr;
                            last_next    = last_addr;
                            single_next  = (first_addr == last_addr);
                            head_next    = 8'hFF >> xs_reg[2:0];
                            tail_next    = 8'hFF << (3'd7 - xe_reg[2:0]);
                            state_next   = hlf_pkg::ST_HEAD;
                        end
                    end
                    hlf_pkg::CMD_READ:
                    begin
                        mem_req.en   = 1'b1;
                        mem_req.addr = hlf_pkg::ADDR_W'(addr_reg);
                        state_next   = hlf_pkg::ST_RD_WAIT;
                    end
                    hlf_pkg::CMD_WRITE:
                    begin
                        mem_req.en    = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.addr  = hlf_pkg::ADDR_W'(addr_reg);
                        mem_req.wdata = wdata_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            hlf_pkg::ST_RD_WAIT:
            begin
                rd_next    = mem_rdata;
                state_next = hlf_pkg::ST_DONE;
            end
            hlf_pkg::ST_HEAD:
            begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = cur_reg;
                if (single_reg)
                begin
                    mem_req.wdata = mem_rdata | (head_reg & tail_reg);
                    state_next    = hlf_pkg::ST_DONE;
                end
                else
                begin
                    mem_req.wdata = mem_rdata | head_reg;
                    cur_next      = cur_reg + 1'b1;
                    state_next    = hlf_pkg::ST_FILL;
                end
            end
            hlf_pkg::ST_FILL:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = cur_reg;
                if (cur_reg == last_reg)
                begin
                    state_next = hlf_pkg::ST_TAIL;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = 8'hFF;
                    cur_next      = cur_reg + 1'b1;
                end
            end
            hlf_pkg::ST_TAIL:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = cur_reg;
                mem_req.wdata = mem_rdata | tail_reg;
                state_next    = hlf_pkg::ST_DONE;
            end
            hlf_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = hlf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hlf_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.status    = status_reg;
    assign res.read_data = rd_reg;

endmodule

### hw/rtl/horizontal_line_fill_unit.sv
`timescale 1ns / 1ps
// Horizontal line fill on a 1-bit-per-pixel frame store (1024 bytes, MSB first).
// Input channel (in_valid/in_ready): one request per command - draw a span
// x_start..x_end on a row, read a byte, or write a byte. Every request gives
// exactly one result (status, read_data) on the output channel
// (out_valid/out_ready), in request order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// sets row_bytes, index 1 sets screen_bytes. Always ready; write only while
// no request is in flight.
// Each request passes CALC and CHECK before DONE; a read adds RD_WAIT, and a
// draw that passes its checks adds HEAD, then FILL and TAIL when it spans
// several bytes. A write and a rejected draw go from CHECK to DONE. The
// single store port sets these steps: a draw reads and writes the end bytes and
// writes one middle byte per cycle. One request is worked at a time; the next
// is taken once the previous result moves into the output register.
// Reset clears the configuration to 16 and 1024 and runs a clearing pass over
// all 1024 bytes of the store, during which in_ready stays low.
// A stalled output holds its result; the unit then finishes at most one more
// request and waits with in_ready low until the output register frees.

module horizontal_line_fill_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [6:0]  x_start,
    input  logic [6:0]  x_end,
    input  logic [9:0]  row,
    input  logic [9:0]  byte_addr,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  read_data
);

    logic [4:0]  row_bytes_reg;
    logic [10:0] screen_bytes_reg;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg;
    logic [7:0]  read_data_reg;

    hlf_pkg::cfg_t     cfg;
    hlf_pkg::mem_req_t mem_req;
    hlf_pkg::res_t     res;
    logic [7:0]        mem_rdata;
    logic              res_valid;
    logic              res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg    <= hlf_pkg::ROW_BYTES_RESET;
            screen_bytes_reg <= hlf_pkg::SCREEN_BYTES_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hlf_pkg::REG_ROW_BYTES:    row_bytes_reg    <= cfg_data[4:0];
                hlf_pkg::REG_SCREEN_BYTES: screen_bytes_reg <= cfg_data;
                default:                   row_bytes_reg    <= row_bytes_reg;
            endcase
        end
    end

    assign cfg.row_bytes  = row_bytes_reg;
    assign cfg.used_bytes = (screen_bytes_reg > hlf_pkg::USED_W'(hlf_pkg::STORE_DEPTH))
                            ? hlf_pkg::USED_W'(hlf_pkg::STORE_DEPTH)
                            : screen_bytes_reg;

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            status_reg    <= res.status;
            read_data_reg <= res.read_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_data = read_data_reg;

    hlf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .x_start    (x_start),
        .x_end      (x_end),
        .row        (row),
        .byte_addr  (byte_addr),
        .write_data (write_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    hlf_ram #(
        .DEPTH (hlf_pkg::STORE_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

endmodule
